### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros: concurrent assertion helpers
// implication checks, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_IMPL(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, ck, rn, ante, cons)
`define ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif

`endif

### rtl/fcc_pkg.sv
// ----------------------------------------------------------------------------
// fcc_pkg: shared definitions for the fat12 cluster chain engine
// operation codes, status codes, register indexes, sequencer types
// ----------------------------------------------------------------------------
package fcc_pkg;

    localparam int DEF_MAX_CLUSTERS = 4096;
    localparam int EPOCH_W          = 8;

    localparam logic [11:0] END_MARK      = 12'hFF8;
    localparam logic [11:0] BAD_MARK      = 12'hFF7;
    localparam logic [11:0] FIRST_CLUSTER = 12'd2;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_NO_SPACE = 2'd1;
    localparam logic [1:0] STAT_RANGE    = 2'd2;

    localparam logic [1:0] CFG_DATA_START = 2'd0;
    localparam logic [1:0] CFG_SPC        = 2'd1;
    localparam logic [1:0] CFG_LIMIT      = 2'd2;

    localparam logic [15:0] RST_DATA_START = 16'd33;
    localparam logic [7:0]  RST_SPC        = 8'd1;
    localparam logic [12:0] RST_LIMIT      = 13'd2849;

    typedef enum logic [2:0] {
        OP_LOAD_BYTE     = 3'd0,
        OP_READ_BYTE     = 3'd1,
        OP_READ_ENTRY    = 3'd2,
        OP_WRITE_ENTRY   = 3'd3,
        OP_FREE_CHAIN    = 3'd4,
        OP_REWRITE_CHAIN = 3'd5
    } op_t;

    typedef struct packed {
        logic [15:0] data_start;
        logic [7:0]  spc;
        logic [12:0] limit;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BYTE,
        ST_FCHK,
        ST_KCHK,
        ST_SCHK,
        ST_ISSUE,
        ST_ER1,
        ST_ER2,
        ST_EW1,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        PH_ENTRY,
        PH_FREE,
        PH_KEEP,
        PH_SRCH,
        PH_LINK,
        PH_TERM
    } phase_t;

endpackage

### rtl/fat12_cluster_chain_engine.sv
// ----------------------------------------------------------------------------
// fat12_cluster_chain_engine: fat12 allocation table engine
// packed 12-bit table in a byte ram, entry access and chain free / rewrite
// ----------------------------------------------------------------------------
// load byte writes on accept; read byte uses BYTE; entry ops ER1, ER2, write EW1
// chain ops: a kept cluster passes KCHK, ER1, ER2, a freed one FCHK, ER1, ER2,
//   EW1, a probed one SCHK, ER1, ER2, a taken one EW1 then ISSUE, ER1, ER2, EW1
//   if linked; one request at a time; a new request is taken while the last
// result waits; after reset the seen-mark ram is swept over all MAX_CLUSTERS
//   entries, no request taken; it repeats once every 255 in-range chain requests
module fat12_cluster_chain_engine #(
    parameter int  MAX_CLUSTERS = fcc_pkg::DEF_MAX_CLUSTERS,
    localparam int TBL_BYTES    = (MAX_CLUSTERS * 3 + 1) / 2,
    localparam int TAW          = $clog2(TBL_BYTES),
    localparam int SAW          = $clog2(MAX_CLUSTERS)
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  operation,
    input  logic [11:0] cluster,
    input  logic [11:0] entry_value,
    input  logic [12:0] byte_address,
    input  logic [7:0]  byte_in,
    input  logic [11:0] cluster_count,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [11:0] next_value,
    output logic [7:0]  byte_out,
    output logic        end_of_chain,
    output logic        entry_free,
    output logic [19:0] sector_address,
    output logic [11:0] chain_head,
    output logic [11:0] freed_count,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    import fcc_pkg::*;

    localparam logic [12:0] MC_L = 13'(MAX_CLUSTERS);

    cfg_t cfg_reg, cfg_next;
    cfg_t cfg_eff;

    logic               tbl_we;
    logic [TAW-1:0]     tbl_waddr;
    logic [7:0]         tbl_wdata;
    logic [TAW-1:0]     tbl_raddr;
    logic [7:0]         tbl_rdata;
    logic               seen_we;
    logic [SAW-1:0]     seen_waddr;
    logic [EPOCH_W-1:0] seen_wdata;
    logic [SAW-1:0]     seen_raddr;
    logic [EPOCH_W-1:0] seen_rdata;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_DATA_START: cfg_next.data_start = cfg_data;
                CFG_SPC:        cfg_next.spc        = cfg_data[7:0];
                CFG_LIMIT:      cfg_next.limit      = cfg_data[12:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.data_start <= RST_DATA_START;
            cfg_reg.spc        <= RST_SPC;
            cfg_reg.limit      <= RST_LIMIT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // usable limit clamped to the table size
    always_comb
    begin
        cfg_eff       = cfg_reg;
        cfg_eff.limit = (cfg_reg.limit > MC_L) ? MC_L : cfg_reg.limit;
    end

    fcc_ram #(
        .WIDTH (8),
        .DEPTH (TBL_BYTES)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    fcc_ram #(
        .WIDTH (EPOCH_W),
        .DEPTH (MAX_CLUSTERS)
    ) u_seen (
        .clk   (clk),
        .we    (seen_we),
        .waddr (seen_waddr),
        .wdata (seen_wdata),
        .raddr (seen_raddr),
        .rdata (seen_rdata)
    );

    fcc_engine #(
        .MAX_CLUSTERS (MAX_CLUSTERS)
    ) u_engine (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_eff),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .cluster        (cluster),
        .entry_value    (entry_value),
        .byte_address   (byte_address),
        .byte_in        (byte_in),
        .cluster_count  (cluster_count),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .next_value     (next_value),
        .byte_out       (byte_out),
        .end_of_chain   (end_of_chain),
        .entry_free     (entry_free),
        .sector_address (sector_address),
        .chain_head     (chain_head),
        .freed_count    (freed_count),
        .tbl_we         (tbl_we),
        .tbl_waddr      (tbl_waddr),
        .tbl_wdata      (tbl_wdata),
        .tbl_raddr      (tbl_raddr),
        .tbl_rdata      (tbl_rdata),
        .seen_we        (seen_we),
        .seen_waddr     (seen_waddr),
        .seen_wdata     (seen_wdata),
        .seen_raddr     (seen_raddr),
        .seen_rdata     (seen_rdata)
    );

endmodule

### rtl/fcc_ram.sv
// ----------------------------------------------------------------------------
// fcc_ram: simple dual-port synchronous ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module fcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/fcc_engine.sv
// ----------------------------------------------------------------------------
// fcc_engine: table sequencer
// byte and entry access, chain walk, free search, seen marks and results
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fcc_engine #(
    parameter int  MAX_CLUSTERS = fcc_pkg::DEF_MAX_CLUSTERS,
    localparam int TBL_BYTES    = (MAX_CLUSTERS * 3 + 1) / 2,
    localparam int TAW          = $clog2(TBL_BYTES),
    localparam int SAW          = $clog2(MAX_CLUSTERS)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fcc_pkg::cfg_t                 cfg,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [2:0]                    operation,
    input  logic [11:0]                   cluster,
    input  logic [11:0]                   entry_value,
    input  logic [12:0]                   byte_address,
    input  logic [7:0]                    byte_in,
    input  logic [11:0]                   cluster_count,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    status,
    output logic [11:0]                   next_value,
    output logic [7:0]                    byte_out,
    output logic                          end_of_chain,
    output logic                          entry_free,
    output logic [19:0]                   sector_address,
    output logic [11:0]                   chain_head,
    output logic [11:0]                   freed_count,
    output logic                          tbl_we,
    output logic [TAW-1:0]                tbl_waddr,
    output logic [7:0]                    tbl_wdata,
    output logic [TAW-1:0]                tbl_raddr,
    input  logic [7:0]                    tbl_rdata,
    output logic                          seen_we,
    output logic [SAW-1:0]                seen_waddr,
    output logic [fcc_pkg::EPOCH_W-1:0]   seen_wdata,
    output logic [SAW-1:0]                seen_raddr,
    input  logic [fcc_pkg::EPOCH_W-1:0]   seen_rdata
);

    import fcc_pkg::*;

    localparam logic [13:0]    TB_L     = 14'(TBL_BYTES);
    localparam logic [SAW-1:0] CLR_LAST = SAW'(MAX_CLUSTERS - 1);

    // byte address of an entry, or of the byte after it
    function automatic logic [TAW-1:0] ent_addr(input logic [11:0] c, input logic plus);
        logic [12:0] t;
        t = {1'b0, c} + {2'b00, c[11:1]} + {12'd0, plus};
        return t[TAW-1:0];
    endfunction

    state_t              state_reg, state_next;
    phase_t              phase_reg, phase_next;
    op_t                 op_reg, op_next;
    logic                bad_reg, bad_next;
    logic [EPOCH_W-1:0]  epoch_reg, epoch_next;
    logic [SAW-1:0]      clr_reg, clr_next;
    logic                clr_ret_reg, clr_ret_next;
    logic                out_valid_reg, out_valid_next;

    logic [11:0] cl_reg, cl_next;
    logic [11:0] ev_reg, ev_next;
    logic [11:0] cnt_reg, cnt_next;
    logic [7:0]  byte_reg, byte_next;
    logic [11:0] raw_reg, raw_next;
    logic [11:0] cur_reg, cur_next;
    logic [11:0] s_reg, s_next;
    logic [11:0] tail_reg, tail_next;
    logic [11:0] head_reg, head_next;
    logic [11:0] kept_reg, kept_next;
    logic [11:0] freed_reg, freed_next;
    logic [11:0] ent_reg, ent_next;
    logic [7:0]  lo_reg, lo_next;
    logic        seen_hit_reg, seen_hit_next;
    logic [15:0] nw_reg, nw_next;
    logic        link_pend_reg, link_pend_next;
    logic [19:0] prod_reg, prod_next;

    logic [1:0]  status_reg;
    logic [11:0] next_value_reg;
    logic [7:0]  byte_out_reg;
    logic        eoc_reg;
    logic        efree_reg;
    logic [19:0] sector_reg;
    logic [11:0] head_out_reg;
    logic [11:0] freed_out_reg;

    op_t         op_in;
    logic        in_bad;
    logic        cur_link_ok;
    logic        keep_go;
    logic        srch_go;
    logic        clr_last;
    state_t      keep_end_st;
    state_t      free_end_st;
    state_t      chain_first;
    logic [11:0] target;
    logic [15:0] word;
    logic [11:0] raw;
    logic [11:0] wval;
    logic [15:0] merged;
    logic        out_load;
    logic        ent_ok;
    logic        chain_ok;
    logic [11:0] clm2;

    assign op_in = op_t'(operation);

    always_comb
    begin
        case (op_in)
            OP_LOAD_BYTE, OP_READ_BYTE:
                in_bad = !({1'b0, byte_address} < TB_L);
            OP_READ_ENTRY, OP_WRITE_ENTRY:
                in_bad = !({1'b0, cluster} < cfg.limit);
            OP_FREE_CHAIN, OP_REWRITE_CHAIN:
                in_bad = (cluster == 12'd1) || !({1'b0, cluster} < cfg.limit);
            default:
                in_bad = 1'b0;
        endcase
    end

    assign cur_link_ok = (cur_reg >= FIRST_CLUSTER) && ({1'b0, cur_reg} < cfg.limit)
                         && (cur_reg < BAD_MARK);
    assign keep_go     = (kept_reg < cnt_reg) && cur_link_ok;
    assign srch_go     = (kept_reg < cnt_reg) && ({1'b0, s_reg} < cfg.limit)
                         && (s_reg < BAD_MARK);
    assign clr_last    = (clr_reg == CLR_LAST);
    assign keep_end_st = (kept_reg == cnt_reg) ? ST_FCHK : ST_SCHK;
    assign free_end_st = (op_reg == OP_FREE_CHAIN) ? ST_DONE : ST_SCHK;
    assign chain_first = (op_reg == OP_FREE_CHAIN) ? ST_FCHK : ST_KCHK;

    assign word = {tbl_rdata, lo_reg};
    assign raw  = ent_reg[0] ? word[15:4] : word[11:0];

    always_comb
    begin
        case (phase_reg)
            PH_ENTRY: wval = ev_reg;
            PH_LINK:  wval = s_reg;
            PH_SRCH,
            PH_TERM:  wval = END_MARK;
            default:  wval = 12'd0;
        endcase
    end

    // keep the neighbor nibble of the shared byte
    assign merged = ent_reg[0] ? {wval, word[3:0]} : {word[15:12], wval};

    always_comb
    begin
        case (state_reg)
            ST_FCHK, ST_KCHK: target = cur_reg;
            ST_SCHK:          target = s_reg;
            ST_ISSUE:         target = tail_reg;
            default:          target = cluster;
        endcase
    end

    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
                if (clr_last)
                begin
                    state_next = clr_ret_reg ? chain_first : ST_IDLE;
                end
            ST_IDLE:
                if (in_valid)
                begin
                    case (op_in)
                        OP_READ_BYTE:
                            state_next = in_bad ? ST_DONE : ST_BYTE;
                        OP_READ_ENTRY, OP_WRITE_ENTRY:
                            state_next = in_bad ? ST_DONE : ST_ER1;
                        OP_FREE_CHAIN:
                            state_next = in_bad ? ST_DONE : (&epoch_reg) ? ST_CLEAR : ST_FCHK;
                        OP_REWRITE_CHAIN:
                            state_next = in_bad ? ST_DONE : (&epoch_reg) ? ST_CLEAR : ST_KCHK;
                        default:
                            state_next = ST_DONE;
                    endcase
                end
            ST_BYTE:
                state_next = ST_DONE;
            ST_FCHK:
                state_next = cur_link_ok ? ST_ER1 : free_end_st;
            ST_KCHK:
                state_next = keep_go ? ST_ER1 : keep_end_st;
            ST_SCHK:
                state_next = srch_go ? ST_ER1 : (kept_reg != 12'd0) ? ST_ISSUE : ST_DONE;
            ST_ISSUE:
                state_next = ST_ER1;
            ST_ER1:
                state_next = ST_ER2;
            ST_ER2:
                case (phase_reg)
                    PH_ENTRY:
                        state_next = (op_reg == OP_WRITE_ENTRY) ? ST_EW1 : ST_DONE;
                    PH_FREE:
                        state_next = (seen_hit_reg || raw == 12'd0) ? free_end_st : ST_EW1;
                    PH_KEEP:
                        state_next = seen_hit_reg ? keep_end_st : ST_KCHK;
                    PH_SRCH:
                        state_next = (seen_hit_reg || raw != 12'd0) ? ST_SCHK : ST_EW1;
                    default:
                        state_next = ST_EW1;
                endcase
            ST_EW1:
                case (phase_reg)
                    PH_FREE: state_next = ST_FCHK;
                    PH_SRCH: state_next = link_pend_reg ? ST_ISSUE : ST_SCHK;
                    PH_LINK: state_next = ST_SCHK;
                    default: state_next = ST_DONE;
                endcase
            ST_DONE:
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = ST_IDLE;
                end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        phase_next     = phase_reg;
        op_next        = op_reg;
        bad_next       = bad_reg;
        epoch_next     = epoch_reg;
        clr_next       = clr_reg;
        clr_ret_next   = clr_ret_reg;
        cl_next        = cl_reg;
        ev_next        = ev_reg;
        cnt_next       = cnt_reg;
        byte_next      = byte_reg;
        raw_next       = raw_reg;
        cur_next       = cur_reg;
        s_next         = s_reg;
        tail_next      = tail_reg;
        head_next      = head_reg;
        kept_next      = kept_reg;
        freed_next     = freed_reg;
        ent_next       = ent_reg;
        lo_next        = lo_reg;
        seen_hit_next  = seen_hit_reg;
        nw_next        = nw_reg;
        link_pend_next = link_pend_reg;

        tbl_we     = 1'b0;
        tbl_waddr  = ent_addr(ent_reg, 1'b0);
        tbl_wdata  = merged[7:0];
        tbl_raddr  = ent_addr(target, 1'b0);
        seen_we    = 1'b0;
        seen_waddr = ent_reg[SAW-1:0];
        seen_wdata = epoch_reg;
        seen_raddr = target[SAW-1:0];

        case (state_reg)
            ST_CLEAR:
            begin
                seen_we    = 1'b1;
                seen_waddr = clr_reg;
                seen_wdata = '0;
                clr_next   = clr_reg + 1'b1;
                if (clr_last)
                begin
                    epoch_next   = clr_ret_reg ? EPOCH_W'(1) : '0;
                    clr_ret_next = 1'b0;
                end
            end
            ST_IDLE:
                if (in_valid)
                begin
                    op_next    = op_in;
                    bad_next   = in_bad;
                    cl_next    = cluster;
                    ev_next    = entry_value;
                    cnt_next   = cluster_count;
                    byte_next  = 8'd0;
                    raw_next   = 12'd0;
                    cur_next   = cluster;
                    ent_next   = cluster;
                    head_next  = 12'd0;
                    kept_next  = 12'd0;
                    freed_next = 12'd0;
                    if (op_in == OP_READ_BYTE)
                    begin
                        tbl_raddr = byte_address[TAW-1:0];
                    end
                    if (op_in == OP_LOAD_BYTE && !in_bad)
                    begin
                        tbl_we    = 1'b1;
                        tbl_waddr = byte_address[TAW-1:0];
                        tbl_wdata = byte_in;
                    end
                    case (op_in)
                        OP_FREE_CHAIN:    phase_next = PH_FREE;
                        OP_REWRITE_CHAIN: phase_next = PH_KEEP;
                        default:          phase_next = PH_ENTRY;
                    endcase
                    if ((op_in == OP_FREE_CHAIN || op_in == OP_REWRITE_CHAIN) && !in_bad)
                    begin
                        if (&epoch_reg)
                        begin
                            clr_next     = '0;
                            clr_ret_next = 1'b1;
                        end
                        else
                        begin
                            epoch_next = epoch_reg + 1'b1;
                        end
                    end
                end
            ST_BYTE:
                byte_next = tbl_rdata;
            ST_FCHK:
                if (cur_link_ok)
                begin
                    ent_next = cur_reg;
                end
                else if (op_reg == OP_REWRITE_CHAIN)
                begin
                    s_next     = FIRST_CLUSTER;
                    phase_next = PH_SRCH;
                end
            ST_KCHK:
                if (keep_go)
                begin
                    ent_next = cur_reg;
                end
                else if (kept_reg == cnt_reg)
                begin
                    phase_next = PH_FREE;
                end
                else
                begin
                    s_next     = FIRST_CLUSTER;
                    phase_next = PH_SRCH;
                end
            ST_SCHK:
                if (srch_go)
                begin
                    ent_next = s_reg;
                end
                else
                begin
                    phase_next = PH_TERM;
                end
            ST_ISSUE:
                ent_next = tail_reg;
            ST_ER1:
            begin
                lo_next       = tbl_rdata;
                seen_hit_next = (seen_rdata == epoch_reg);
                tbl_raddr     = ent_addr(ent_reg, 1'b1);
            end
            ST_ER2:
            begin
                nw_next = merged;
                tbl_we  = (state_next == ST_EW1);
                case (phase_reg)
                    PH_ENTRY:
                        raw_next = (op_reg == OP_WRITE_ENTRY) ? ev_reg : raw;
                    PH_FREE:
                        if (seen_hit_reg || raw == 12'd0)
                        begin
                            if (op_reg == OP_REWRITE_CHAIN)
                            begin
                                s_next     = FIRST_CLUSTER;
                                phase_next = PH_SRCH;
                            end
                        end
                        else
                        begin
                            seen_we    = 1'b1;
                            freed_next = freed_reg + 1'b1;
                            cur_next   = raw;
                        end
                    PH_KEEP:
                        if (seen_hit_reg)
                        begin
                            if (kept_reg == cnt_reg)
                            begin
                                phase_next = PH_FREE;
                            end
                            else
                            begin
                                s_next     = FIRST_CLUSTER;
                                phase_next = PH_SRCH;
                            end
                        end
                        else
                        begin
                            seen_we = 1'b1;
                            if (kept_reg == 12'd0)
                            begin
                                head_next = ent_reg;
                            end
                            tail_next = ent_reg;
                            kept_next = kept_reg + 1'b1;
                            cur_next  = raw;
                        end
                    PH_SRCH:
                        if (seen_hit_reg || raw != 12'd0)
                        begin
                            s_next = s_reg + 1'b1;
                        end
                        else
                        begin
                            seen_we = 1'b1;
                            if (kept_reg == 12'd0)
                            begin
                                head_next = ent_reg;
                            end
                            link_pend_next = (kept_reg != 12'd0);
                            kept_next      = kept_reg + 1'b1;
                        end
                    default:
                        ;
                endcase
            end
            ST_EW1:
            begin
                tbl_we    = 1'b1;
                tbl_waddr = ent_addr(ent_reg, 1'b1);
                tbl_wdata = nw_reg[15:8];
                case (phase_reg)
                    PH_SRCH:
                        if (link_pend_reg)
                        begin
                            phase_next = PH_LINK;
                        end
                        else
                        begin
                            tail_next = s_reg;
                            s_next    = s_reg + 1'b1;
                        end
                    PH_LINK:
                    begin
                        tail_next  = s_reg;
                        s_next     = s_reg + 1'b1;
                        phase_next = PH_SRCH;
                    end
                    default:
                        ;
                endcase
            end
            default:
                ;
        endcase
    end

    assign clm2      = cl_reg - FIRST_CLUSTER;
    assign prod_next = {8'd0, clm2} * {12'd0, cfg.spc};

    assign out_valid_next = out_load ? 1'b1 : (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            phase_reg     <= PH_ENTRY;
            op_reg        <= OP_LOAD_BYTE;
            bad_reg       <= 1'b0;
            epoch_reg     <= '0;
            clr_reg       <= '0;
            clr_ret_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            op_reg        <= op_next;
            bad_reg       <= bad_next;
            epoch_reg     <= epoch_next;
            clr_reg       <= clr_next;
            clr_ret_reg   <= clr_ret_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cl_reg        <= cl_next;
        ev_reg        <= ev_next;
        cnt_reg       <= cnt_next;
        byte_reg      <= byte_next;
        raw_reg       <= raw_next;
        cur_reg       <= cur_next;
        s_reg         <= s_next;
        tail_reg      <= tail_next;
        head_reg      <= head_next;
        kept_reg      <= kept_next;
        freed_reg     <= freed_next;
        ent_reg       <= ent_next;
        lo_reg        <= lo_next;
        seen_hit_reg  <= seen_hit_next;
        nw_reg        <= nw_next;
        link_pend_reg <= link_pend_next;
        prod_reg      <= prod_next;
    end

    assign ent_ok   = (op_reg == OP_READ_ENTRY || op_reg == OP_WRITE_ENTRY) && !bad_reg;
    assign chain_ok = (op_reg == OP_FREE_CHAIN || op_reg == OP_REWRITE_CHAIN) && !bad_reg;

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (bad_reg)
            begin
                status_reg <= STAT_RANGE;
            end
            else if (op_reg == OP_REWRITE_CHAIN && kept_reg < cnt_reg)
            begin
                status_reg <= STAT_NO_SPACE;
            end
            else
            begin
                status_reg <= STAT_OK;
            end
            next_value_reg <= (ent_ok && raw_reg < END_MARK) ? raw_reg : 12'd0;
            eoc_reg        <= ent_ok && (raw_reg >= END_MARK);
            efree_reg      <= ent_ok && (raw_reg == 12'd0);
            sector_reg     <= (ent_ok && cl_reg >= FIRST_CLUSTER)
                              ? ({4'd0, cfg.data_start} + prod_reg) : 20'd0;
            byte_out_reg   <= byte_reg;
            head_out_reg   <= (chain_ok && op_reg == OP_REWRITE_CHAIN && kept_reg != 12'd0)
                              ? head_reg : 12'd0;
            freed_out_reg  <= chain_ok ? freed_reg : 12'd0;
        end
    end

    assign in_stall       = (state_reg != ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign next_value     = next_value_reg;
    assign byte_out       = byte_out_reg;
    assign end_of_chain   = eoc_reg;
    assign entry_free     = efree_reg;
    assign sector_address = sector_reg;
    assign chain_head     = head_out_reg;
    assign freed_count    = freed_out_reg;

    `ASSERT_IMPL(a_tbl_waddr, clk, rst_n, tbl_we, {1'b0, tbl_waddr} < TB_L[TAW:0])
    `ASSERT_IMPL(a_seen_epoch, clk, rst_n, seen_we && state_reg != ST_CLEAR, epoch_reg != '0)
    `ASSERT_IMPL(a_kept_bound, clk, rst_n, state_reg != ST_IDLE && op_reg == OP_REWRITE_CHAIN && !bad_reg && state_reg != ST_CLEAR, kept_reg <= cnt_reg)
    `ASSERT_NEXT(a_done_loads, clk, rst_n, state_reg == ST_DONE && !out_valid_reg, out_valid_reg && state_reg == ST_IDLE)

endmodule
